>>> sv/trilinear_grid_interpolator_assert.svh
// Assertion macros for the trilinear grid interpolator.
`ifndef TRILINEAR_GRID_INTERPOLATOR_ASSERT_SVH
`define TRILINEAR_GRID_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TGI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGI_ASSERT(lbl, prop, msg)
`define TGI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/tgi_pkg.sv
// Types and constants of the trilinear grid interpolator.
`default_nettype none
package tgi_pkg;

  // item kind carried on s_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // component select
  localparam logic [1:0] COMP_U    = 2'd0;
  localparam logic [1:0] COMP_V    = 2'd1;
  localparam logic [1:0] COMP_W    = 2'd2;
  localparam logic [1:0] COMP_NONE = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_CELL_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_CELL_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_CELL_Z = 3'd5;

  // field widths
  localparam int unsigned CELL_BITS   = 5;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned POS_BITS    = 32;
  localparam int unsigned INV_BITS    = 24;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [INV_BITS-1:0] INV_RESET = 24'd65536;

  // sequencer counter width and last step indexes
  localparam int unsigned CNT_BITS   = 4;
  localparam logic [CNT_BITS-1:0] AXIS_LAST  = 4'd3;
  localparam logic [CNT_BITS-1:0] BLEND_LAST = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AXIS,
    ST_BLEND,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/trilinear_grid_interpolator.sv
// Trilinear grid interpolator: grid memory, axis scaling and blend sequencer.
// Write items: one per cycle while idle, stored at the accept edge, no result.
// Query: axis scaling on one shared multiplier, then corner reads through the single
//   memory read port overlapped with the shared blender, then a load of the output
//   register; the next item is accepted only once the result has been loaded.
// Out-of-domain query or component three: the blend is skipped, result from done step.
// Reset clears control and origin registers, presets inv_cell_*; grid memory undefined.
`default_nettype none
module trilinear_grid_interpolator #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input items
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // cell_x[4:0] cell_y[9:5] cell_z[14:10] sample_u[30:15] sample_v[46:31]
  // sample_w[62:47] pos_x[94:63] pos_y[126:95] pos_z[158:127] component[160:159]
  input  wire logic [tgi_pkg::IN_TDATA_W-1:0]       s_tdata,
  // command[0]
  input  wire logic                                 s_tuser,
  // result items
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // value[15:0]
  output logic [tgi_pkg::OUT_TDATA_W-1:0]           m_tdata,
  // in_domain[0]
  output logic                                      m_tuser,
  // configuration writes
  input  wire logic                                 cfg_we,
  input  wire logic [tgi_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [tgi_pkg::POS_BITS-1:0]         cfg_data
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int SB    = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int PW    = tgi_pkg::POS_BITS + 1 + tgi_pkg::INV_BITS + 1;
  localparam int HW    = PW - tgi_pkg::POS_BITS;
  localparam logic [HW-1:0] LIM_X = HW'(GRID_X - 2);
  localparam logic [HW-1:0] LIM_Y = HW'(GRID_Y - 2);
  localparam logic [HW-1:0] LIM_Z = HW'(GRID_Z - 2);

  // input field unpacking
  logic [tgi_pkg::CELL_BITS-1:0]   in_cell_x, in_cell_y, in_cell_z;
  logic [tgi_pkg::SAMPLE_BITS-1:0] in_u, in_v, in_w;
  logic [tgi_pkg::POS_BITS-1:0]    in_pos_x, in_pos_y, in_pos_z;
  logic [1:0]                      in_comp;

  assign in_cell_x = s_tdata[4:0];
  assign in_cell_y = s_tdata[9:5];
  assign in_cell_z = s_tdata[14:10];
  assign in_u      = s_tdata[30:15];
  assign in_v      = s_tdata[46:31];
  assign in_w      = s_tdata[62:47];
  assign in_pos_x  = s_tdata[94:63];
  assign in_pos_y  = s_tdata[126:95];
  assign in_pos_z  = s_tdata[158:127];
  assign in_comp   = s_tdata[160:159];

  // configuration registers
  logic [tgi_pkg::POS_BITS-1:0] origin_x, origin_y, origin_z;
  logic [tgi_pkg::INV_BITS-1:0] inv_cell_x, inv_cell_y, inv_cell_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      inv_cell_x <= tgi_pkg::INV_RESET;
      inv_cell_y <= tgi_pkg::INV_RESET;
      inv_cell_z <= tgi_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgi_pkg::REG_ORIGIN_X:   origin_x   <= cfg_data;
        tgi_pkg::REG_ORIGIN_Y:   origin_y   <= cfg_data;
        tgi_pkg::REG_ORIGIN_Z:   origin_z   <= cfg_data;
        tgi_pkg::REG_INV_CELL_X: inv_cell_x <= cfg_data[tgi_pkg::INV_BITS-1:0];
        tgi_pkg::REG_INV_CELL_Y: inv_cell_y <= cfg_data[tgi_pkg::INV_BITS-1:0];
        tgi_pkg::REG_INV_CELL_Z: inv_cell_z <= cfg_data[tgi_pkg::INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  tgi_pkg::state_t state, state_next;
  logic [tgi_pkg::CNT_BITS-1:0] cnt;
  logic accept, is_query, is_write, load_out, axis_bad, go_blend;

  assign accept   = s_tvalid && s_tready;
  assign is_query = accept && (s_tuser == tgi_pkg::CMD_QUERY);
  assign is_write = accept && (s_tuser == tgi_pkg::CMD_WRITE);

  // query registers
  logic signed [tgi_pkg::POS_BITS:0] d_x, d_y, d_z;
  logic [1:0]                        comp;
  logic                              dom_ok;
  logic signed [PW-1:0]              prod;
  logic [XW-1:0]                     ix;
  logic [YW-1:0]                     iy;
  logic [ZW-1:0]                     iz;
  logic [tgi_pkg::FRAC_BITS-1:0]     fx, fy, fz;

  assign go_blend = dom_ok && !axis_bad && (comp != tgi_pkg::COMP_NONE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tgi_pkg::ST_IDLE:  if (is_query) state_next = tgi_pkg::ST_AXIS;
      tgi_pkg::ST_AXIS:  begin
        if (cnt == tgi_pkg::AXIS_LAST) begin
          state_next = go_blend ? tgi_pkg::ST_BLEND : tgi_pkg::ST_DONE;
        end
      end
      tgi_pkg::ST_BLEND: if (cnt == tgi_pkg::BLEND_LAST) state_next = tgi_pkg::ST_DONE;
      tgi_pkg::ST_DONE:  if (load_out) state_next = tgi_pkg::ST_IDLE;
      default:           state_next = tgi_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      tgi_pkg::ST_IDLE:  s_tready = 1'b1;
      tgi_pkg::ST_DONE:  load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgi_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // grid memory: one write port (write items), one registered read port (corners)
  logic [3*SB-1:0] mem [DEPTH];
  logic [3*SB-1:0] rdata;
  logic [AW-1:0]   waddr, raddr;
  logic            wr_ok;

  assign wr_ok = (int'(in_cell_x) < GRID_X) && (int'(in_cell_y) < GRID_Y)
                 && (int'(in_cell_z) < GRID_Z);
  assign waddr = {ZW'(in_cell_z), YW'(in_cell_y), XW'(in_cell_x)};
  assign raddr = {ZW'(iz + ZW'(cnt[2])), YW'(iy + YW'(cnt[1])), XW'(ix + XW'(cnt[0]))};

  always_ff @(posedge clk) begin
    if (is_write && wr_ok) begin
      mem[waddr] <= {in_w[SB-1:0], in_v[SB-1:0], in_u[SB-1:0]};
    end
    rdata <= mem[raddr];
  end

  // axis scaling: one shared multiplier, axis x, y, z in turn
  logic signed [tgi_pkg::POS_BITS:0] mul_d;
  logic [tgi_pkg::INV_BITS-1:0]      mul_inv;
  logic [HW-1:0]                     prod_hi;
  logic [HW-1:0]                     lim;

  always_comb begin
    case (cnt[1:0])
      2'd0:    begin mul_d = d_x; mul_inv = inv_cell_x; end
      2'd1:    begin mul_d = d_y; mul_inv = inv_cell_y; end
      default: begin mul_d = d_z; mul_inv = inv_cell_z; end
    endcase
  end

  // decode the product of the axis multiplied in the previous cycle
  assign prod_hi = prod[PW-1:tgi_pkg::POS_BITS];
  always_comb begin
    case (cnt[1:0])
      2'd1:    lim = LIM_X;
      2'd2:    lim = LIM_Y;
      default: lim = LIM_Z;
    endcase
  end
  assign axis_bad = (cnt != '0) && (prod[PW-1] || (prod_hi > lim));

  // blender: a + (b - a) * f, rounded to nearest
  logic signed [15:0]             bl_a, bl_b;
  logic [tgi_pkg::FRAC_BITS-1:0]  bl_f;
  logic signed [16:0]             bl_diff;
  logic signed [33:0]             bl_mul;
  logic [34:0]                    bl_sum;
  logic [15:0]                    bl_out;
  logic [SB-1:0]                  seg;
  logic signed [15:0]             corner;
  logic signed [15:0]             ca, t0, t1, t2;
  logic [15:0]                    res_val;

  always_comb begin
    case (comp)
      tgi_pkg::COMP_U: seg = rdata[SB-1:0];
      tgi_pkg::COMP_V: seg = rdata[2*SB-1:SB];
      default:         seg = rdata[3*SB-1:2*SB];
    endcase
  end
  assign corner = 16'($signed(seg));

  // operand selection per blend step
  always_comb begin
    bl_a = ca;
    bl_b = corner;
    bl_f = fx;
    case (cnt)
      4'd5:    begin bl_a = t0; bl_b = t1; bl_f = fy; end
      4'd9:    begin bl_a = t1; bl_b = t2; bl_f = fy; end
      4'd10:   begin bl_a = t0; bl_b = t1; bl_f = fz; end
      default: ;
    endcase
  end

  assign bl_diff = {bl_b[15], bl_b} - {bl_a[15], bl_a};
  assign bl_mul  = bl_diff * $signed({1'b0, bl_f});
  assign bl_sum  = {{3{bl_a[15]}}, bl_a, 16'h0000} + {bl_mul[33], bl_mul} + 35'd32768;
  assign bl_out  = bl_sum[31:16];

  // datapath registers
  always_ff @(posedge clk) begin
    if (is_query) begin
      d_x     <= {in_pos_x[31], in_pos_x} - {origin_x[31], origin_x};
      d_y     <= {in_pos_y[31], in_pos_y} - {origin_y[31], origin_y};
      d_z     <= {in_pos_z[31], in_pos_z} - {origin_z[31], origin_z};
      comp    <= in_comp;
      res_val <= '0;
    end
    if (state == tgi_pkg::ST_AXIS) begin
      prod <= mul_d * $signed({1'b0, mul_inv});
      case (cnt[1:0])
        2'd1:    begin ix <= prod[tgi_pkg::POS_BITS +: XW]; fx <= prod[31:16]; end
        2'd2:    begin iy <= prod[tgi_pkg::POS_BITS +: YW]; fy <= prod[31:16]; end
        2'd3:    begin iz <= prod[tgi_pkg::POS_BITS +: ZW]; fz <= prod[31:16]; end
        default: ;
      endcase
    end
    if (state == tgi_pkg::ST_BLEND) begin
      case (cnt)
        4'd1, 4'd3, 4'd5, 4'd7: ca <= corner;
        default: ;
      endcase
      case (cnt)
        4'd2, 4'd5: t0 <= bl_out;
        4'd4, 4'd6, 4'd9: t1 <= bl_out;
        4'd8:  t2 <= bl_out;
        4'd10: res_val <= bl_out;
        default: ;
      endcase
    end
  end

  // domain flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dom_ok <= 1'b0;
    end else if (is_query) begin
      dom_ok <= 1'b1;
    end else if (state == tgi_pkg::ST_AXIS && axis_bad) begin
      dom_ok <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= dom_ok ? res_val : '0;
      m_tuser <= dom_ok;
    end
  end

  `include "trilinear_grid_interpolator_assert.svh"

  `TGI_ASSERT(a_query_starts_axis, is_query |=> (state == tgi_pkg::ST_AXIS && cnt == '0), "query did not start axis scaling")
  `TGI_ASSERT(a_result_from_done, $rose(m_tvalid) |-> $past(state) == tgi_pkg::ST_DONE, "result appeared outside done step")
  `TGI_ASSERT(a_blend_in_domain, state == tgi_pkg::ST_BLEND |-> (dom_ok && cnt <= tgi_pkg::BLEND_LAST), "blend without valid domain")
  `TGI_ASSERT(a_out_zero, (m_tvalid && !m_tuser) |-> m_tdata == '0, "out of domain result not zero")
  `TGI_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == tgi_pkg::ST_IDLE && !m_tvalid), "reset did not clear sequencer")

endmodule
`default_nettype wire
